[rtl/core/speech_sample_resampler_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the speech sample resampler core
// Clocked, reset-qualified property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SPEECH_SAMPLE_RESAMPLER_CORE_DEFINES_SVH
`define SPEECH_SAMPLE_RESAMPLER_CORE_DEFINES_SVH

// same-cycle implication
`define SRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srs assertion failed");

// next-cycle implication
`define SRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srs assertion failed");

`endif

[rtl/core/srs_pkg.sv]
// ----------------------------------------------------------------------------
// srs_pkg
// Shared constants, codes, types and the loudness table of the resampler.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int MAX_RUN = 64;
    localparam int RUN_W   = $clog2(MAX_RUN + 1);
    localparam int IDX_W   = 19;
    localparam int POS_W   = 24;
    localparam int LVL_W   = 8;
    localparam int MODE_W  = 3;
    localparam int DIV_W   = 16;
    localparam int DVS_W   = 8;
    localparam int PROD_W  = 16;

    // volume modes
    localparam logic [MODE_W-1:0] VOL_PASS    = 3'd0;
    localparam logic [MODE_W-1:0] VOL_NIBBLE  = 3'd1;
    localparam logic [MODE_W-1:0] VOL_WIDE    = 3'd2;
    localparam logic [MODE_W-1:0] VOL_NARROW  = 3'd3;
    localparam logic [MODE_W-1:0] VOL_TABLE   = 3'd4;

    // render modes
    localparam logic [MODE_W-1:0] REND_SILENT       = 3'd0;
    localparam logic [MODE_W-1:0] REND_COARSE_HOLD  = 3'd1;
    localparam logic [MODE_W-1:0] REND_COARSE_SMTH  = 3'd2;
    localparam logic [MODE_W-1:0] REND_FINE_HOLD    = 3'd3;

    // register indexes
    localparam logic CFG_VOLUME = 1'b0;
    localparam logic CFG_RENDER = 1'b1;

    // clamp-stretch limits
    localparam logic [LVL_W-1:0] WIDE_LO    = 8'd32;
    localparam logic [LVL_W-1:0] WIDE_HI    = 8'd224;
    localparam logic [LVL_W-1:0] WIDE_SPAN  = 8'd192;
    localparam logic [LVL_W-1:0] NARROW_LO  = 8'd48;
    localparam logic [LVL_W-1:0] NARROW_HI  = 8'd208;
    localparam logic [LVL_W-1:0] NARROW_SPAN = 8'd160;

    // x * 255 / 192 == x * 85 / 64, x * 255 / 160 == x * 51 / 32
    localparam logic [PROD_W-1:0] WIDE_MUL   = 16'd85;
    localparam int                WIDE_SH    = 6;
    localparam logic [PROD_W-1:0] NARROW_MUL = 16'd51;
    localparam int                NARROW_SH  = 5;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [LVL_W-1:0] loud_lut(input logic [3:0] idx);
        logic [LVL_W-1:0] v;
        case (idx)
            4'd0:    v = 8'd0;
            4'd1:    v = 8'd1;
            4'd2:    v = 8'd2;
            4'd3:    v = 8'd4;
            4'd4:    v = 8'd8;
            4'd5:    v = 8'd16;
            4'd6:    v = 8'd32;
            4'd7:    v = 8'd64;
            4'd8:    v = 8'd128;
            4'd9:    v = 8'd192;
            4'd10:   v = 8'd224;
            4'd11:   v = 8'd240;
            4'd12:   v = 8'd248;
            4'd13:   v = 8'd252;
            4'd14:   v = 8'd254;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/srs_remap.sv]
// ----------------------------------------------------------------------------
// srs_remap
// Loudness remap front end: pass, nibble fill, clamp-stretch and table.
// ----------------------------------------------------------------------------
module srs_remap
    import srs_pkg::*;
(
    input  logic [LVL_W-1:0]  level,
    input  logic [MODE_W-1:0] volume_mode,
    output logic [LVL_W-1:0]  value
);

    logic [LVL_W-1:0]  clamped;
    logic [LVL_W-1:0]  offset;
    logic [LVL_W-1:0]  lo;
    logic [LVL_W-1:0]  hi;
    logic [PROD_W-1:0] wide_prod;
    logic [PROD_W-1:0] narrow_prod;

    always_comb
    begin
        lo = (volume_mode == VOL_WIDE) ? WIDE_LO : NARROW_LO;
        hi = (volume_mode == VOL_WIDE) ? WIDE_HI : NARROW_HI;
        if (level < lo)
            clamped = lo;
        else if (level > hi)
            clamped = hi;
        else
            clamped = level;
        offset      = clamped - lo;
        wide_prod   = {{(PROD_W-LVL_W){1'b0}}, offset} * WIDE_MUL;
        narrow_prod = {{(PROD_W-LVL_W){1'b0}}, offset} * NARROW_MUL;
    end

    always_comb
    begin
        case (volume_mode)
            VOL_NIBBLE: value = level | {4'd0, level[7:4]};
            VOL_WIDE:   value = wide_prod[WIDE_SH +: LVL_W];
            VOL_NARROW: value = narrow_prod[NARROW_SH +: LVL_W];
            VOL_TABLE:  value = loud_lut(level[7:4]);
            default:    value = level;
        endcase
    end

endmodule

[rtl/core/srs_div.sv]
// ----------------------------------------------------------------------------
// srs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srs_div
    import srs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   shifted;
    logic             fits;
    logic [DVS_W:0]   diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/core/speech_sample_resampler_core.sv]
// ----------------------------------------------------------------------------
// speech_sample_resampler_core
// Remaps a synthesizer sample and expands it into a held or ramped run.
// ----------------------------------------------------------------------------
// Usage: s_* takes one item (tuser = restart command, tdata = position then
//   level). m_* gives output samples (tdata = sample, tlast = final sample
//   of the run, tuser = run was clamped to MAX_RUN). Config writes
//   (cfg_we/cfg_index/cfg_data) belong between items, while idle.
// Timing: restart and silent-mode items end in ST_IDLE; sample items go
//   through ST_REMAP and ST_PLAN. A run gives up to 64 samples, then
//   closes; smooth modes first run the ramp step divide (serial divider,
//   one quotient bit per cycle). s_tready is high only between runs.
// Reset: clears index and level, volume_mode = 4, render_mode = 1.
// Stall: the output register holds its sample while m_tready is low and
//   the run pauses.
// ----------------------------------------------------------------------------
module speech_sample_resampler_core
    import srs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [MODE_W-1:0] cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // position[23:0], level[31:24]
    input  logic [0:0]        s_tuser,   // command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // sample
    output logic              m_tlast,   // last
    output logic [0:0]        m_tuser    // clipped
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_REMAP = 5'b00010,
        ST_PLAN  = 5'b00100,
        ST_SDIV  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] vol_reg, vol_next;
    logic [MODE_W-1:0] rend_reg, rend_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [LVL_W-1:0]  prev_reg, prev_next;
    logic [RUN_W-1:0]  cnt_reg, cnt_next;
    logic              mvalid_reg, mvalid_next;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [LVL_W-1:0]  b_reg, b_next;
    logic [LVL_W-1:0]  cur_reg, cur_next;
    logic [LVL_W-1:0]  step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic              clip_reg, clip_next;
    logic [LVL_W-1:0]  msample_reg, msample_next;
    logic              mlast_reg, mlast_next;

    logic [LVL_W-1:0]  remap_value;
    div_req_t          dreq;
    div_rsp_t          drsp;

    logic              smooth;
    logic              coarse;
    logic [IDX_W-1:0]  target;
    logic [IDX_W-1:0]  gap;
    logic              ahead;
    logic              clip;
    logic [LVL_W-1:0]  mag;
    logic              fin;
    logic              load_ok;

    srs_remap u_remap
    (
        .level       (lvl_reg),
        .volume_mode (vol_reg),
        .value       (remap_value)
    );

    srs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        smooth  = !(rend_reg == REND_COARSE_HOLD || rend_reg == REND_FINE_HOLD);
        coarse  = (rend_reg == REND_COARSE_HOLD || rend_reg == REND_COARSE_SMTH);
        target  = coarse ? {1'b0, pos_reg[POS_W-1:6]} : pos_reg[POS_W-1:5];
        ahead   = target > idx_reg;
        gap     = target - idx_reg;
        clip    = gap > IDX_W'(MAX_RUN);
        mag     = (b_reg < prev_reg) ? (prev_reg - b_reg) : (b_reg - prev_reg);
        fin     = (cnt_reg == run_reg - 1'b1);
        load_ok = !mvalid_reg || m_tready;
    end

    always_comb
    begin
        state_next   = state_reg;
        vol_next     = vol_reg;
        rend_next    = rend_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        cnt_next     = cnt_reg;
        mvalid_next  = mvalid_reg;
        pos_next     = pos_reg;
        lvl_next     = lvl_reg;
        b_next       = b_reg;
        cur_next     = cur_reg;
        step_next    = step_reg;
        neg_next     = neg_reg;
        run_next     = run_reg;
        clip_next    = clip_reg;
        msample_next = msample_reg;
        mlast_next   = mlast_reg;
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VOLUME: vol_next  = cfg_data;
                CFG_RENDER: rend_next = cfg_data;
                default:    vol_next  = vol_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0])
                    begin
                        idx_next  = '0;
                        prev_next = '0;
                    end
                    else if (rend_reg != REND_SILENT)
                    begin
                        pos_next   = s_tdata[POS_W-1:0];
                        lvl_next   = s_tdata[31:24];
                        state_next = ST_REMAP;
                    end
                end
            end
            ST_REMAP:
            begin
                b_next     = remap_value;
                state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                if (smooth)
                    prev_next = b_reg;
                if (!ahead)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next  = target;
                    run_next  = clip ? RUN_W'(MAX_RUN) : gap[RUN_W-1:0];
                    clip_next = clip;
                    cur_next  = prev_reg;
                    cnt_next  = '0;
                    neg_next  = b_reg < prev_reg;
                    step_next = '0;
                    if (smooth)
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = {{(DIV_W-LVL_W){1'b0}}, mag};
                        dreq.divisor  = DVS_W'(clip ? RUN_W'(MAX_RUN) : gap[RUN_W-1:0]);
                        state_next    = ST_SDIV;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SDIV:
            begin
                if (drsp.done)
                begin
                    step_next  = neg_reg ? (~drsp.quotient[LVL_W-1:0] + 1'b1)
                                         : drsp.quotient[LVL_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    if (cnt_reg != run_reg)
                    begin
                        mvalid_next  = 1'b1;
                        msample_next = (!smooth || fin) ? b_reg : (cur_reg + step_reg);
                        mlast_next   = fin;
                        cur_next     = cur_reg + step_reg;
                        cnt_next     = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        mvalid_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next  = ST_IDLE;
                mvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vol_reg    <= VOL_TABLE;
            rend_reg   <= REND_COARSE_HOLD;
            idx_reg    <= '0;
            prev_reg   <= '0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            vol_reg    <= vol_next;
            rend_reg   <= rend_next;
            idx_reg    <= idx_next;
            prev_reg   <= prev_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        lvl_reg     <= lvl_next;
        b_reg       <= b_next;
        cur_reg     <= cur_next;
        step_reg    <= step_next;
        neg_reg     <= neg_next;
        run_reg     <= run_next;
        clip_reg    <= clip_next;
        msample_reg <= msample_next;
        mlast_reg   <= mlast_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = msample_reg;
    assign m_tlast    = mlast_reg;
    assign m_tuser[0] = clip_reg;

endmodule

[rtl/core/srs_checker.sv]
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks of the resampler core, bound into the core module.
// ----------------------------------------------------------------------------
`include "speech_sample_resampler_core_defines.svh"

module srs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // no new item while a run is on the output
    `SRS_ASSERT_IMP(a_no_accept_in_run, m_tvalid, !s_tready)

    // stalled output holds
    `SRS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // run closes after its final transfer
    `SRS_ASSERT_NXT(a_run_close, m_tvalid && m_tready && m_tlast, !m_tvalid)

    // after a restart the core is idle and ready again in the next cycle
    `SRS_ASSERT_NXT(a_restart_quick, s_tvalid && s_tready && s_tuser[0],
        s_tready && !m_tvalid)

endmodule

bind speech_sample_resampler_core srs_checker u_srs_checker (.*);

[sim/speech_sample_resampler_core_test.sv]
// ----------------------------------------------------------------------------
// speech_sample_resampler_core_test
// Self-checking bench for the resampler core. It walks a table of directed
// transfers, then runs random phases under several volume and render settings.
// Each accepted input is run through a local loudness/ramp predictor, and
// every output transfer is compared field by field with the oldest expected
// sample. Both stream sides idle at random, and one phase holds off the
// output for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module speech_sample_resampler_core_test;
    import srs_pkg::*;

    localparam logic       CMD_SAMPLE     = 1'b0;
    localparam logic       CMD_RESTART    = 1'b1;
    localparam logic [2:0] REND_FINE_SMTH = 3'd4;
    localparam int         GAP_MAX        = 12;
    localparam int         SETTLE_CYCLES  = 64;
    localparam int         CHOKE_CYCLES   = 400;
    localparam int         CYCLE_LIMIT    = 1000000;
    localparam int         PHASES         = 5;
    localparam int         PHASE_ITEMS    = 16;

    // loudness curve, entry 0 in the lowest byte
    localparam logic [127:0] LOUD_CURVE = {
        8'd255, 8'd254, 8'd252, 8'd248, 8'd240, 8'd224, 8'd192, 8'd128,
        8'd64,  8'd32,  8'd16,  8'd8,   8'd4,   8'd2,   8'd1,   8'd0
    };

    typedef struct packed {
        logic [7:0] smp;
        logic       fin;
        logic       clp;
    } out_beat_t;

    typedef struct packed {
        logic [2:0]  vol;
        logic [2:0]  rend;
        logic        cmd;
        logic [23:0] pos;
        logic [7:0]  lvl;
        logic        typed;
        logic [6:0]  n;
        logic [7:0]  smp;
        logic        clp;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [MODE_W-1:0] cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    // predictor state and register shadow
    logic [2:0]  vol_mode   = VOL_TABLE;
    logic [2:0]  rend_mode  = REND_COARSE_HOLD;
    logic [18:0] at_index   = '0;
    logic [7:0]  last_level = '0;

    out_beat_t   ramp_beats[$];
    out_beat_t   pending_beats[$];
    plan_row_t   plan[$];

    int  tx_gap      = 0;
    bit  tx_calm     = 1'b0;
    bit  rx_calm     = 1'b0;
    int  rx_gap      = 0;
    int  choke_left  = 0;
    bit  choke_go    = 1'b0;
    bit  choke_done  = 1'b0;
    int  cycle_count = 0;
    int  mismatches  = 0;
    int  items_sent  = 0;
    int  restarts    = 0;
    int  settings    = 0;
    int  beats_seen  = 0;
    int  clipped_seen = 0;

    speech_sample_resampler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d samples still expected",
                     cycle_count, pending_beats.size());
            $display("speech_sample_resampler_core_test failed");
            $finish;
        end
    end

    function automatic int pick_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    function automatic logic [7:0] loudness_remap(logic [2:0] mode, logic [7:0] raw);
        int unsigned v;
        v = raw;
        case (mode)
            VOL_NIBBLE:
                return raw | (raw >> 4);
            VOL_WIDE:
            begin
                if (v < WIDE_LO) v = WIDE_LO;
                if (v > WIDE_HI) v = WIDE_HI;
                return 8'((v - WIDE_LO) * 255 / WIDE_SPAN);
            end
            VOL_NARROW:
            begin
                if (v < NARROW_LO) v = NARROW_LO;
                if (v > NARROW_HI) v = NARROW_HI;
                return 8'((v - NARROW_LO) * 255 / NARROW_SPAN);
            end
            VOL_TABLE:
                return LOUD_CURVE[raw[7:4] * 8 +: 8];
            default:
                return raw;
        endcase
    endfunction

    // expected output run of one input, left in ramp_beats
    function automatic void predict_run(logic cmd, logic [23:0] pos, logic [7:0] raw);
        logic [7:0]  lvl;
        logic [18:0] tgt;
        logic [7:0]  smp;
        int          run;
        int          stepv;
        int          cur;
        bit          smooth;
        bit          clip;
        ramp_beats.delete();
        if (cmd == CMD_RESTART)
        begin
            at_index   = '0;
            last_level = '0;
            return;
        end
        if (rend_mode == REND_SILENT)
            return;
        lvl    = loudness_remap(vol_mode, raw);
        smooth = !(rend_mode == REND_COARSE_HOLD || rend_mode == REND_FINE_HOLD);
        if (rend_mode == REND_COARSE_HOLD || rend_mode == REND_COARSE_SMTH)
            tgt = 19'(pos >> 6);
        else
            tgt = 19'(pos >> 5);
        if (tgt <= at_index)
        begin
            if (smooth)
                last_level = lvl;
            return;
        end
        run  = int'(tgt - at_index);
        clip = run > MAX_RUN;
        if (clip)
            run = MAX_RUN;
        cur   = int'(last_level);
        stepv = (int'(lvl) - int'(last_level)) / run;
        for (int k = 0; k < run; k++)
        begin
            if (smooth && k < run - 1)
            begin
                cur += stepv;
                smp = 8'(cur);
            end
            else
                smp = lvl;
            ramp_beats.push_back(out_beat_t'{smp, k == run - 1, clip});
        end
        at_index = tgt;
        if (smooth)
            last_level = lvl;
    endfunction

    task automatic check_beat(logic [7:0] smp, logic fin, logic clp);
        out_beat_t want;
        beats_seen++;
        if (fin && clp)
            clipped_seen++;
        if (pending_beats.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transfer: sample %0d last %0b clipped %0b",
                         smp, fin, clp);
            return;
        end
        want = pending_beats.pop_front();
        if (want.smp !== smp || want.fin !== fin || want.clp !== clp)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at output %0d: sample %0d/%0d last %0b/%0b clipped %0b/%0b",
                         beats_seen, want.smp, smp, want.fin, fin, want.clp, clp);
        end
    endtask

    // output side: random stalls, plus one long hold-off
    always @(posedge clk)
    begin : rx_side
        int g;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            rx_gap     <= 0;
            choke_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_beat(m_tdata, m_tlast, m_tuser[0]);
            if (choke_go && !choke_done)
            begin
                choke_done <= 1'b1;
                choke_left <= CHOKE_CYCLES;
                rx_gap     <= 0;
                m_tready   <= 1'b0;
            end
            else if (choke_left > 0)
            begin
                choke_left <= choke_left - 1;
                if (choke_left == 1)
                    m_tready <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                g = pick_gap(rx_calm);
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    rx_gap   <= g;
                end
            end
            else if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
                if (rx_gap == 1)
                    m_tready <= 1'b1;
            end
            else if (!m_tready)
                m_tready <= 1'b1;
        end
    end

    task automatic send_item(logic cmd, logic [23:0] pos, logic [7:0] lvl,
                             logic typed, int n, logic [7:0] smp, logic clp);
        repeat (tx_gap) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {lvl, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_run(cmd, pos, lvl);
        if (typed)
        begin
            for (int k = 0; k < n; k++)
                pending_beats.push_back(out_beat_t'{smp, k == n - 1, clp});
        end
        else
        begin
            foreach (ramp_beats[k])
                pending_beats.push_back(ramp_beats[k]);
        end
        items_sent++;
        tx_gap = pick_gap(tx_calm);
        if (tx_gap > 0)
            s_tvalid <= 1'b0;
    endtask

    // drain all outputs, then give a trailing no-output item time to finish
    task automatic settle();
        if (tx_gap == 0)
            s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_modes(logic [2:0] vol, logic [2:0] rend);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VOLUME;
        cfg_data  <= vol;
        @(posedge clk);
        vol_mode = vol;
        cfg_index <= CFG_RENDER;
        cfg_data  <= rend;
        @(posedge clk);
        rend_mode = rend;
        cfg_we <= 1'b0;
        settings++;
    endtask

    // mostly short runs just ahead of the index, some stale, clamped or wild
    task automatic random_item();
        int          r;
        int          d;
        int          tval;
        int          top;
        int          sh;
        logic [23:0] pos;
        logic [7:0]  lvl;
        logic        cmd;
        r   = $urandom_range(0, 99);
        sh  = (rend_mode == REND_COARSE_HOLD || rend_mode == REND_COARSE_SMTH) ? 6 : 5;
        top = (1 << (24 - sh)) - 1;
        cmd = CMD_SAMPLE;
        d   = $urandom_range(1, 12);
        if (r < 6)
            cmd = CMD_RESTART;
        else if (r < 14)
            d = 0 - int'($urandom_range(0, 40));
        else if (r < 22)
            d = $urandom_range(MAX_RUN + 1, 4 * MAX_RUN);
        tval = int'(at_index) + d;
        if (tval < 0)
            tval = 0;
        if (tval > top)
            tval = top;
        pos = 24'(tval << sh) | 24'($urandom_range(0, (1 << sh) - 1));
        if (r < 6 || (r >= 22 && r < 26))
            pos = 24'($urandom);
        if ($urandom_range(0, 9) < 7)
            lvl = {4'($urandom_range(0, 15)), 4'h0};
        else
            lvl = 8'($urandom);
        if (cmd == CMD_RESTART)
            restarts++;
        send_item(cmd, pos, lvl, 1'b0, 0, 8'h00, 1'b0);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;

        //                      vol         rend              cmd          pos          lvl
        //                      typed n      sample  clipped
        plan.push_back(plan_row_t'{VOL_TABLE, REND_COARSE_HOLD, CMD_SAMPLE, 24'h000040, 8'hF0,
                                   1'b1, 7'd1,  8'd255, 1'b0});
        plan.push_back(plan_row_t'{VOL_TABLE, REND_COARSE_HOLD, CMD_SAMPLE, 24'h000040, 8'h00,
                                   1'b1, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_TABLE, REND_COARSE_HOLD, CMD_SAMPLE, 24'h000FFF, 8'h80,
                                   1'b1, 7'd62, 8'd128, 1'b0});
        plan.push_back(plan_row_t'{VOL_TABLE, REND_COARSE_HOLD, CMD_SAMPLE, 24'hFFFFFF, 8'hFF,
                                   1'b1, 7'd64, 8'd255, 1'b1});
        plan.push_back(plan_row_t'{VOL_TABLE, REND_COARSE_HOLD, CMD_RESTART, 24'hFFFFFF, 8'hFF,
                                   1'b1, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_PASS, REND_COARSE_HOLD, CMD_SAMPLE, 24'h0000C0, 8'h5A,
                                   1'b1, 7'd3,  8'h5A,  1'b0});
        plan.push_back(plan_row_t'{VOL_NIBBLE, REND_COARSE_SMTH, CMD_SAMPLE, 24'h000200, 8'h90,
                                   1'b0, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_WIDE, REND_COARSE_SMTH, CMD_SAMPLE, 24'h000400, 8'h10,
                                   1'b0, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_WIDE, REND_FINE_SMTH, CMD_SAMPLE, 24'h000C00, 8'hFF,
                                   1'b0, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_NARROW, REND_FINE_SMTH, CMD_SAMPLE, 24'h000C20, 8'h20,
                                   1'b0, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_NARROW, REND_FINE_HOLD, CMD_SAMPLE, 24'h000C40, 8'hD0,
                                   1'b1, 7'd1,  8'd255, 1'b0});
        plan.push_back(plan_row_t'{VOL_NARROW, REND_FINE_HOLD, CMD_SAMPLE, 24'h000800, 8'h40,
                                   1'b1, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_PASS, REND_SILENT, CMD_SAMPLE, 24'hFFFFFF, 8'hFF,
                                   1'b1, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{3'd5, REND_FINE_SMTH, CMD_SAMPLE, 24'h001000, 8'h37,
                                   1'b0, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{3'd7, 3'd7, CMD_SAMPLE, 24'h001020, 8'hC8,
                                   1'b0, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{3'd6, 3'd5, CMD_SAMPLE, 24'h000020, 8'h01,
                                   1'b1, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{3'd6, 3'd6, CMD_SAMPLE, 24'h001100, 8'hFE,
                                   1'b0, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_WIDE, REND_COARSE_HOLD, CMD_SAMPLE, 24'h003000, 8'h80,
                                   1'b0, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_TABLE, REND_FINE_SMTH, CMD_RESTART, 24'h000000, 8'h00,
                                   1'b1, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_TABLE, REND_FINE_SMTH, CMD_SAMPLE, 24'hFFFFFF, 8'hA0,
                                   1'b0, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_TABLE, REND_COARSE_SMTH, CMD_SAMPLE, 24'h000000, 8'h00,
                                   1'b1, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_NIBBLE, REND_COARSE_SMTH, CMD_RESTART, 24'h5A5A5A, 8'hA5,
                                   1'b1, 7'd0,  8'd0,   1'b0});
        plan.push_back(plan_row_t'{VOL_NIBBLE, REND_COARSE_SMTH, CMD_SAMPLE, 24'h000040, 8'hF0,
                                   1'b1, 7'd1,  8'd255, 1'b0});
        plan.push_back(plan_row_t'{VOL_NIBBLE, REND_FINE_SMTH, CMD_SAMPLE, 24'h0000C0, 8'h2F,
                                   1'b0, 7'd0,  8'd0,   1'b0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].cmd == CMD_RESTART)
                restarts++;
            if (plan[i].vol != vol_mode || plan[i].rend != rend_mode)
                set_modes(plan[i].vol, plan[i].rend);
            send_item(plan[i].cmd, plan[i].pos, plan[i].lvl, plan[i].typed,
                      int'(plan[i].n), plan[i].smp, plan[i].clp);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_modes(VOL_WIDE, REND_COARSE_SMTH);
                1:       set_modes(3'd7, REND_FINE_SMTH);
                2:       set_modes(VOL_PASS, 3'd7);
                default: set_modes(3'($urandom_range(0, 7)), 3'($urandom_range(1, 7)));
            endcase
            tx_calm = ($urandom_range(0, 2) == 0);
            rx_calm = ($urandom_range(0, 2) == 0);
            if (p == 1)
            begin
                // keep offering inputs while the output is held off
                tx_calm  = 1'b1;
                choke_go = 1'b1;
            end
            repeat (PHASE_ITEMS) random_item();
        end

        settle();
        $display("run covered %0d input transfers (%0d restarts) over %0d register settings",
                 items_sent, restarts, settings);
        $display("%0d output samples checked, %0d clamped runs, %0d mismatches",
                 beats_seen, clipped_seen, mismatches);
        if (mismatches == 0)
            $display("speech_sample_resampler_core_test passed");
        else
            $display("speech_sample_resampler_core_test failed");
        $finish;
    end

endmodule
